@@ sv/tbwr_pkg.sv @@
// Shared types and constants for the tile background/window renderer.
// No dependencies; imported by every module of the block.
package tbwr_pkg;

  // Video memory: 8 KiB of bytes, held as 4096 16-bit words (even byte low).
  localparam int VRAM_BYTES  = 8192;
  localparam int VRAM_ADDR_W = 13;
  localparam int VRAM_WORDS  = VRAM_BYTES / 2;
  localparam int WORD_ADDR_W = 12;

  localparam int SCREEN_WIDTH    = 160;
  localparam int SCREEN_LINES    = 144;
  localparam int WINDOW_X_OFFSET = 7;

  // Both tile maps sit in the top 2 KiB of video memory (0x9800 and 0x9C00).
  localparam logic [1:0] MAP_REGION = 2'b11;

  // Request kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_Y    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_X    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_Y    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_X    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BG_PALETTE  = 3'd5;

  // LCD control bit positions.
  localparam int LCDC_BG_ENABLE  = 0;
  localparam int LCDC_BG_MAP     = 3;
  localparam int LCDC_DATA_SEL   = 4;
  localparam int LCDC_WIN_ENABLE = 5;
  localparam int LCDC_WIN_MAP    = 6;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic                   is_write;
    logic [VRAM_ADDR_W-1:0] addr;    // write address, or tile map entry address
    logic [7:0]             wdata;
    logic                   drawn;
    logic                   win;
    logic [2:0]             row;     // row inside the tile
    logic [2:0]             px;      // pixel inside the tile row
    logic [7:0]             col;
    logic [7:0]             line;
  } tbwr_item_t;

  // Configuration the back end needs.
  typedef struct packed {
    logic       data_unsigned;
    logic [7:0] palette;
  } tbwr_back_cfg_t;

endpackage

@@ sv/tbwr_front.sv @@
// Front end: configuration registers and request classification.
// Depends on tbwr_pkg; feeds tbwr_queue and supplies tbwr_back with settings.
module tbwr_front
  import tbwr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   kind,
  input  logic [VRAM_ADDR_W-1:0] vram_offset,
  input  logic [7:0]             vram_byte,
  input  logic [7:0]             column,
  input  logic [7:0]             line,
  output tbwr_item_t             item,
  output tbwr_back_cfg_t         back_cfg
);

  logic [7:0] lcd_control;
  logic [7:0] scroll_y;
  logic [7:0] scroll_x;
  logic [7:0] window_y;
  logic [7:0] window_x;
  logic [7:0] bg_palette;

  logic [7:0] win_start;
  logic       on_screen;
  logic       drawn;
  logic       win;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic       map_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control <= '0;
      scroll_y    <= '0;
      scroll_x    <= '0;
      window_y    <= '0;
      window_x    <= '0;
      bg_palette  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LCD_CONTROL: lcd_control <= cfg_data;
        REG_SCROLL_Y:    scroll_y    <= cfg_data;
        REG_SCROLL_X:    scroll_x    <= cfg_data;
        REG_WINDOW_Y:    window_y    <= cfg_data;
        REG_WINDOW_X:    window_x    <= cfg_data;
        REG_BG_PALETTE:  bg_palette  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    win_start = (window_x < 8'(WINDOW_X_OFFSET)) ? 8'd0 : window_x - 8'(WINDOW_X_OFFSET);
    on_screen = (column < 8'(SCREEN_WIDTH)) && (line < 8'(SCREEN_LINES));
    drawn     = lcd_control[LCDC_BG_ENABLE] && on_screen;
    // Columns left of the window start fall back to the scrolled background.
    win       = drawn && lcd_control[LCDC_WIN_ENABLE] && (window_y <= line)
                && (column >= win_start);
    if (win) begin
      pos_x   = column - win_start;
      pos_y   = line - window_y;
      map_sel = lcd_control[LCDC_WIN_MAP];
    end else begin
      pos_x   = column + scroll_x;
      pos_y   = line + scroll_y;
      map_sel = lcd_control[LCDC_BG_MAP];
    end

    item.is_write = (kind == KIND_WRITE);
    item.addr     = (kind == KIND_WRITE) ? vram_offset
                                         : {MAP_REGION, map_sel, pos_y[7:3], pos_x[7:3]};
    item.wdata    = vram_byte;
    item.drawn    = drawn;
    item.win      = win;
    item.row      = pos_y[2:0];
    item.px       = pos_x[2:0];
    item.col      = column;
    item.line     = line;

    back_cfg.data_unsigned = lcd_control[LCDC_DATA_SEL];
    back_cfg.palette       = bg_palette;
  end

endmodule

@@ sv/tbwr_queue.sv @@
// Short request queue between the front and back ends.
// Depends on tbwr_pkg for the item type.
module tbwr_queue
  import tbwr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tbwr_item_t push_item,
  output logic       not_full,
  input  logic       pop,
  output logic       head_valid,
  output tbwr_item_t head_item
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  tbwr_item_t         slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign not_full   = (count != COUNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/tbwr_back.sv @@
// Back end: video memory, tile map read, tile row read and output register.
// Depends on tbwr_pkg; takes requests from tbwr_queue.
module tbwr_back
  import tbwr_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tbwr_item_t     head_item,
  output logic           pop,
  input  tbwr_back_cfg_t back_cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           drawn,
  output logic [1:0]     color_id,
  output logic [1:0]     shade,
  output logic           from_window,
  output logic [7:0]     out_column,
  output logic [7:0]     out_line
);

  // Word w holds byte 2w in bits 7:0 and byte 2w+1 in bits 15:8, so a tile
  // row (low plane at an even address) comes out of one read.
  logic [15:0] vram [VRAM_WORDS];

  logic       advance;
  logic       s1_valid;
  tbwr_item_t s1;
  logic [15:0] map_word;
  logic       s2_valid;
  tbwr_item_t s2;
  logic [15:0] tile_word;

  logic [7:0]             tile_num;
  logic [WORD_ADDR_W-1:0] tile_addr;
  logic [2:0]             bit_sel;
  logic [1:0]             cid;
  logic [1:0]             pal_shade;

  // The whole back end moves together; it stops only when a finished
  // result is still waiting at the output.
  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid;

  always_ff @(posedge clk) begin
    if (pop && head_item.is_write) begin
      if (head_item.addr[0]) begin
        vram[head_item.addr[VRAM_ADDR_W-1:1]][15:8] <= head_item.wdata;
      end else begin
        vram[head_item.addr[VRAM_ADDR_W-1:1]][7:0] <= head_item.wdata;
      end
    end
    if (advance) begin
      map_word  <= vram[head_item.addr[VRAM_ADDR_W-1:1]];
      tile_word <= vram[tile_addr];
    end
  end

  always_comb begin
    tile_num = s1.addr[0] ? map_word[15:8] : map_word[7:0];
    // Signed tile data puts tiles 0..127 at 0x9000 and 128..255 at 0x8800,
    // which only flips the top address bit against the unsigned layout.
    tile_addr = {!back_cfg.data_unsigned && !tile_num[7], tile_num, s1.row};

    bit_sel = 3'd7 - s2.px;
    cid     = {tile_word[4'd8 + {1'b0, bit_sel}], tile_word[{1'b0, bit_sel}]};
    case (cid)
      2'd0:    pal_shade = back_cfg.palette[1:0];
      2'd1:    pal_shade = back_cfg.palette[3:2];
      2'd2:    pal_shade = back_cfg.palette[5:4];
      2'd3:    pal_shade = back_cfg.palette[7:6];
      default: pal_shade = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= head_item;
      s2 <= s1;
      drawn       <= s2.drawn;
      color_id    <= s2.drawn ? cid : 2'd0;
      shade       <= s2.drawn ? pal_shade : 2'd0;
      from_window <= s2.drawn && s2.win;
      out_column  <= s2.col;
      out_line    <= s2.line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= head_valid && !head_item.is_write;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

@@ sv/tile_background_window_renderer.sv @@
// Top level of the tile background/window pixel renderer.
// Depends on tbwr_pkg, tbwr_front, tbwr_queue and tbwr_back.
//
//   Channel   Handshake              Carries
//   input     in_valid / in_ready    kind, vram_offset, vram_byte, column, line
//   output    out_valid / out_ready  drawn, color_id, shade, from_window,
//                                    out_column, out_line
//   config    cfg_write              cfg_index, cfg_data (no wait, no read-back)
//
// One request per cycle is taken while the queue has room; a result passes the
// queue, tile map read, tile row read and output register. The video memory sets
// the rate; it serves the map and tile row reads of two pixels in the same cycle.
// Reset clears the registers and the pipeline; video memory is not cleared.
// A stalled output holds the back end, and the front keeps taking requests until
// the queue of QUEUE_DEPTH entries fills.
module tile_background_window_renderer
  import tbwr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic [VRAM_ADDR_W-1:0] vram_offset,
  input  logic [7:0]             vram_byte,
  input  logic [7:0]             column,
  input  logic [7:0]             line,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   drawn,
  output logic [1:0]             color_id,
  output logic [1:0]             shade,
  output logic                   from_window,
  output logic [7:0]             out_column,
  output logic [7:0]             out_line
);

  tbwr_item_t     front_item;
  tbwr_back_cfg_t back_cfg;
  logic           head_valid;
  tbwr_item_t     head_item;
  logic           pop;

  tbwr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .vram_offset (vram_offset),
    .vram_byte   (vram_byte),
    .column      (column),
    .line        (line),
    .item        (front_item),
    .back_cfg    (back_cfg)
  );

  tbwr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && in_ready),
    .push_item  (front_item),
    .not_full   (in_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tbwr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .back_cfg    (back_cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drawn       (drawn),
    .color_id    (color_id),
    .shade       (shade),
    .from_window (from_window),
    .out_column  (out_column),
    .out_line    (out_line)
  );

endmodule

@@ sv/tbwr_checker.sv @@
// Port-level checks for the tile background/window renderer.
// Depends on tbwr_pkg; bound to tile_background_window_renderer below.
module tbwr_checker
  import tbwr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drawn,
  input logic [1:0] color_id,
  input logic [1:0] shade,
  input logic       from_window,
  input logic [7:0] out_column,
  input logic [7:0] out_line
);

  // Reset empties the pipeline, so no result is offered right after it.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A drawn pixel can only come from an on-screen request.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && drawn) |-> (out_column < 8'(SCREEN_WIDTH)) && (out_line < 8'(SCREEN_LINES)))
    else $error("drawn pixel lies off screen");

  // Pixels not drawn carry no colour and no window flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drawn) |-> (color_id == 2'd0) && (shade == 2'd0) && !from_window)
    else $error("undrawn pixel carries colour data");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(drawn) && $stable(color_id)
      && $stable(shade) && $stable(from_window) && $stable(out_column)
      && $stable(out_line))
    else $error("stalled result changed");

endmodule

bind tile_background_window_renderer tbwr_checker u_tbwr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .drawn       (drawn),
  .color_id    (color_id),
  .shade       (shade),
  .from_window (from_window),
  .out_column  (out_column),
  .out_line    (out_line)
);
